// ===== rtl/core/smpc_pkg.sv =====
// Package for the sliding-mode position controller: fixed-point widths,
// saturation helpers, register indexes and the microcode program.
// No dependencies; imported by sliding_mode_position_control.
`default_nettype none

package smpc_pkg;

  // Integer part width of the internal fixed-point format (Q(DATA_WIDTH).16)
  localparam int DATA_WIDTH = 32;
  localparam int VW    = DATA_WIDTH + 16;        // internal value width, signed
  localparam int EW    = VW + 1;                 // sum width before saturation
  localparam int MAG_W = VW - 1;                 // magnitude width
  localparam int HI_W  = (MAG_W > 32) ? MAG_W - 32 : 1;
  localparam int ML_W  = 32 + HI_W;              // magnitude split as lo32 + hi
  localparam int PW    = ML_W + 32;              // full product width

  localparam int CFG_AW = 3;
  localparam int PC_W   = 5;
  localparam int PH_W   = 5;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_INERTIA  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_REACH    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SLOPE    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SWITCH   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_BOUNDARY = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SCALE    = 3'd5;

  // Saturation limits and fixed constants
  localparam logic signed [VW-1:0] LIM   = {1'b0, {MAG_W{1'b1}}};
  localparam logic signed [EW-1:0] LIM_E = {2'b00, {MAG_W{1'b1}}};
  localparam logic [PW-1:0]        LIM_PW = {{(PW-MAG_W){1'b0}}, {MAG_W{1'b1}}};
  localparam logic signed [VW-1:0] ONE_Q      = VW'(65536);
  localparam logic signed [VW-1:0] ERR_THRESH = VW'(6553);
  localparam logic signed [VW-1:0] CMD_LIM_Q  = VW'(64'd16384 << 16);
  localparam logic signed [EW-1:0] OFFSET_E   = EW'(64'd1000 << 16);
  localparam logic [31:0]          RATE_GAIN  = 32'd500 << 16;
  localparam logic [31:0]          ACCEL_GAIN = 32'd10 << 16;
  localparam logic signed [15:0]   CMD_POS    = 16'sd16384;
  localparam logic signed [15:0]   CMD_NEG    = -16'sd16384;

  // Last sub-step of the multi-cycle operations
  localparam logic [PH_W-1:0] MUL_LAST = 5'd4;
  localparam logic [PH_W-1:0] SAT_LAST = 5'd18;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_SAT, OP_SKIP, OP_OFFS, OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    R_T, R_POS, R_VEL, R_T1, R_T2, R_A, R_X, R_DT, R_DDT,
    R_ERR, R_DERR, R_S, R_SUM, R_CMD
  } reg_id_t;

  typedef enum logic [2:0] {
    C_RATE, C_ACCEL, C_INERTIA, C_REACH, C_SLOPE, C_SWITCH, C_SCALE
  } coef_t;

  typedef struct packed {
    op_t     op;
    reg_id_t src_a;
    reg_id_t src_b;
    coef_t   coef;
    reg_id_t dst;
  } ctrl_word_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // Saturate a widened sum back into the internal range
  function automatic logic signed [VW-1:0] sat_val(input logic signed [EW-1:0] v);
    logic signed [VW-1:0] r;
    if (v > LIM_E)       r = LIM;
    else if (v < -LIM_E) r = -LIM;
    else                 r = v[VW-1:0];
    return r;
  endfunction

  // Sign-extend a 32-bit input word and saturate it
  function automatic logic signed [VW-1:0] ext32(input logic [31:0] v);
    logic signed [EW-1:0] e;
    e = {{(EW-32){v[31]}}, v};
    return sat_val(e);
  endfunction

  // Control program, one word per step
  function automatic ctrl_word_t prog_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      5'd0:  w = '{OP_SUB,  R_T,    R_T1,   C_RATE,    R_A};
      5'd1:  w = '{OP_MUL,  R_A,    R_A,    C_RATE,    R_DT};
      5'd2:  w = '{OP_SUB,  R_A,    R_T1,   C_RATE,    R_X};
      5'd3:  w = '{OP_ADD,  R_X,    R_T2,   C_RATE,    R_X};
      5'd4:  w = '{OP_MUL,  R_X,    R_X,    C_ACCEL,   R_DDT};
      5'd5:  w = '{OP_SUB,  R_T,    R_POS,  C_RATE,    R_ERR};
      5'd6:  w = '{OP_SUB,  R_DT,   R_VEL,  C_RATE,    R_DERR};
      5'd7:  w = '{OP_MUL,  R_ERR,  R_ERR,  C_SLOPE,   R_X};
      5'd8:  w = '{OP_ADD,  R_X,    R_DERR, C_RATE,    R_S};
      5'd9:  w = '{OP_SAT,  R_S,    R_S,    C_RATE,    R_X};
      5'd10: w = '{OP_MUL,  R_X,    R_X,    C_SWITCH,  R_SUM};
      5'd11: w = '{OP_MUL,  R_S,    R_S,    C_REACH,   R_X};
      5'd12: w = '{OP_ADD,  R_SUM,  R_X,    C_RATE,    R_SUM};
      5'd13: w = '{OP_ADD,  R_SUM,  R_DDT,  C_RATE,    R_SUM};
      5'd14: w = '{OP_MUL,  R_DERR, R_DERR, C_SLOPE,   R_X};
      5'd15: w = '{OP_ADD,  R_SUM,  R_X,    C_RATE,    R_SUM};
      5'd16: w = '{OP_MUL,  R_SUM,  R_SUM,  C_INERTIA, R_X};
      5'd17: w = '{OP_MUL,  R_X,    R_X,    C_SCALE,   R_CMD};
      5'd18: w = '{OP_SKIP, R_ERR,  R_CMD,  C_RATE,    R_CMD};
      5'd19: w = '{OP_OFFS, R_CMD,  R_CMD,  C_RATE,    R_CMD};
      default: w = '{OP_OUT, R_CMD, R_CMD,  C_RATE,    R_CMD};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sliding_mode_position_control.sv =====
// Sliding-mode position controller with boundary-layer saturation.
// Microcoded datapath: one shared 32x32 multiplier and a bit-serial divider.
// Depends on smpc_pkg.
//
// Usage:
//  - in_* channel: one transaction per control tick carrying target angle,
//    measured position and measured velocity (signed Q16.16).
//  - out_* channel: one transaction per input: the clamped integer drive
//    command on out_tdata and the clamp flag on out_tuser.
//  - cfg_*: write-only register port, must be written while the block is idle (the block does not enforce this).
//  - Sequencing: the program runs 21 steps; an add is a single combinational step, each of the
//    eight products runs in sub-steps on the shared multiplier, the saturation
//    quotient is built in the one-bit-per-cycle divider. The result is
//    registered at the output step (the offset step may be skipped), and
//    in_tready rises at that edge; a new input is accepted only after that.
//  - Receiver stall: the result sits in the output register; the next item
//    is accepted and processed meanwhile and waits at its last step until
//    the output register frees.
//  - Reset (rst_n low, synchronous) returns to idle, clears the two stored
//    targets and loads the configuration reset values.
`default_nettype none

module sliding_mode_position_control (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // in_tdata: target_angle[31:0], position[63:32], velocity[95:64]
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [95:0]                in_tdata,
  // out_tdata: drive_command[15:0]
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [15:0]                     out_tdata,
  // out_tuser: clamped[0]
  output logic                            out_tuser,
  input  wire logic                       cfg_wr_en,
  input  wire logic [smpc_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [31:0]                cfg_wr_data
);
  import smpc_pkg::*;

  state_t            state_r;
  logic [PC_W-1:0]   pc_r;
  logic [PH_W-1:0]   ph_r;

  // Configuration registers
  logic [31:0] inertia_r, reach_r, slope_r, switch_r, boundary_r, scale_r;

  // Input words and stored targets, raw 32-bit
  logic [31:0] t_r, pos_r, vel_r, t1_r, t2_r;

  // Working registers
  logic signed [VW-1:0] a_r, x_r, dt_r, ddt_r, err_r, derr_r, s_r, sum_r, cmd_r;

  // Multiplier / divider registers
  logic            neg_r;
  logic [ML_W-1:0] mag_r;
  logic [31:0]     coef_r;
  logic [63:0]     p_r, lo_r;
  logic [PW-1:0]   full_r;
  logic [32:0]     rem_r;
  logic [16:0]     q_r;

  // Output register
  logic        out_tvalid_r;
  logic [15:0] out_data_r;
  logic        out_flag_r;

  ctrl_word_t cw;
  logic signed [VW-1:0] opa, opb, abs_a;
  logic signed [VW-1:0] add_res, sub_res, offs_res, mul_res, sat_res, res_val;
  logic [31:0]     coef_sel, mop;
  logic [63:0]     prod;
  logic [PW-1:0]   mul_q;
  logic signed [VW-1:0] mul_mag, sat_mag, tr_mag, cmd_int;
  logic [32:0]     rem_sh;
  logic            div_ge, sat_gt, skip_take, wr_en, step_done, out_free;
  logic            out_load;
  logic [15:0]     cmd_word;
  logic            cmd_flag;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flag_r;
  assign out_free   = !out_tvalid_r || out_tready;

  assign cw = prog_rom(pc_r);

  // Result moves into the output register at the output step
  assign out_load = (state_r == ST_RUN) && (cw.op == OP_OUT) && out_free;

  // Operand select
  function automatic logic signed [VW-1:0] src_val(input reg_id_t id,
      input logic [31:0] t, pos, vel, t1, t2,
      input logic signed [VW-1:0] a, x, dt, ddt, err, derr, s, sum, cmd);
    logic signed [VW-1:0] v;
    unique case (id)
      R_T:    v = ext32(t);
      R_POS:  v = ext32(pos);
      R_VEL:  v = ext32(vel);
      R_T1:   v = ext32(t1);
      R_T2:   v = ext32(t2);
      R_A:    v = a;
      R_X:    v = x;
      R_DT:   v = dt;
      R_DDT:  v = ddt;
      R_ERR:  v = err;
      R_DERR: v = derr;
      R_S:    v = s;
      R_SUM:  v = sum;
      default: v = cmd;
    endcase
    return v;
  endfunction

  assign opa = src_val(cw.src_a, t_r, pos_r, vel_r, t1_r, t2_r,
                       a_r, x_r, dt_r, ddt_r, err_r, derr_r, s_r, sum_r, cmd_r);
  assign opb = src_val(cw.src_b, t_r, pos_r, vel_r, t1_r, t2_r,
                       a_r, x_r, dt_r, ddt_r, err_r, derr_r, s_r, sum_r, cmd_r);

  // Coefficient select
  always_comb begin
    unique case (cw.coef)
      C_RATE:    coef_sel = RATE_GAIN;
      C_ACCEL:   coef_sel = ACCEL_GAIN;
      C_INERTIA: coef_sel = inertia_r;
      C_REACH:   coef_sel = reach_r;
      C_SLOPE:   coef_sel = slope_r;
      C_SWITCH:  coef_sel = switch_r;
      default:   coef_sel = scale_r;
    endcase
  end

  // Saturating add / subtract / offset
  assign add_res  = sat_val({opa[VW-1], opa} + {opb[VW-1], opb});
  assign sub_res  = sat_val({opa[VW-1], opa} - {opb[VW-1], opb});
  assign offs_res = sat_val(opa[VW-1] ? ({opa[VW-1], opa} - OFFSET_E)
                                      : ({opa[VW-1], opa} + OFFSET_E));
  assign abs_a    = opa[VW-1] ? -opa : opa;

  // Shared multiplier: low 32 bits of the magnitude, then the high part
  assign mop     = (ph_r == 5'd1) ? mag_r[31:0] : 32'(mag_r[ML_W-1:32]);
  assign prod    = mop * coef_r;
  assign mul_q   = full_r >> 16;
  assign mul_mag = (mul_q > LIM_PW) ? LIM : mul_q[VW-1:0];
  assign mul_res = neg_r ? -mul_mag : mul_mag;

  // Restoring divider step, first step without shift
  assign rem_sh  = (ph_r == 5'd1) ? rem_r : {rem_r[31:0], 1'b0};
  assign div_ge  = rem_sh >= {1'b0, boundary_r};
  assign sat_gt  = mag_r > ML_W'(boundary_r);
  assign sat_mag = sat_gt ? ONE_Q : ((boundary_r == 32'd0) ? '0 : VW'(q_r));
  assign sat_res = neg_r ? -sat_mag : sat_mag;

  // Offset condition: error above threshold and nonzero command
  assign skip_take = (opa > ERR_THRESH) && (opb != '0);

  // Final clamp and truncation toward zero
  assign tr_mag  = abs_a >>> 16;
  assign cmd_int = opa[VW-1] ? -tr_mag : tr_mag;
  always_comb begin
    if (opa > CMD_LIM_Q) begin
      cmd_word = CMD_POS;
      cmd_flag = 1'b1;
    end else if (opa < -CMD_LIM_Q) begin
      cmd_word = CMD_NEG;
      cmd_flag = 1'b1;
    end else begin
      cmd_word = cmd_int[15:0];
      cmd_flag = 1'b0;
    end
  end

  // Step decode: result, write strobe, step completion
  always_comb begin
    res_val   = add_res;
    wr_en     = 1'b0;
    step_done = 1'b1;
    unique case (cw.op)
      OP_ADD: begin
        wr_en = 1'b1;
      end
      OP_SUB: begin
        res_val = sub_res;
        wr_en   = 1'b1;
      end
      OP_MUL: begin
        res_val   = mul_res;
        wr_en     = (ph_r == MUL_LAST);
        step_done = (ph_r == MUL_LAST);
      end
      OP_SAT: begin
        res_val   = sat_res;
        wr_en     = (ph_r == SAT_LAST);
        step_done = (ph_r == SAT_LAST);
      end
      OP_OFFS: begin
        res_val = offs_res;
        wr_en   = 1'b1;
      end
      OP_OUT: begin
        step_done = out_free;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inertia_r  <= 32'd2621;
      reach_r    <= 32'd2621440;
      slope_r    <= 32'd1310720;
      switch_r   <= 32'd1966080;
      boundary_r <= 32'd65536;
      scale_r    <= 32'd65536;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_INERTIA:  inertia_r  <= cfg_wr_data;
        REG_REACH:    reach_r    <= cfg_wr_data;
        REG_SLOPE:    slope_r    <= cfg_wr_data;
        REG_SWITCH:   switch_r   <= cfg_wr_data;
        REG_BOUNDARY: boundary_r <= cfg_wr_data;
        REG_SCALE:    scale_r    <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Sequencer control and stored targets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pc_r         <= '0;
      ph_r         <= '0;
      t1_r         <= '0;
      t2_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // output valid: a new load takes precedence over the draining transaction
      if (out_load)                        out_tvalid_r <= 1'b1;
      else if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            state_r <= ST_RUN;
            pc_r    <= '0;
            ph_r    <= '0;
          end
        end
        ST_RUN: begin
          if (!step_done) begin
            ph_r <= ph_r + 5'd1;
          end else begin
            ph_r <= '0;
            if (cw.op == OP_SKIP && !skip_take) pc_r <= pc_r + 5'd2;
            else                                pc_r <= pc_r + 5'd1;
            if (cw.op == OP_OUT) begin
              state_r <= ST_IDLE;
              t2_r    <= t1_r;
              t1_r    <= t_r;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath payload registers
  always_ff @(posedge clk) begin
    // capture input transaction
    if (in_tvalid && in_tready) begin
      t_r   <= in_tdata[31:0];
      pos_r <= in_tdata[63:32];
      vel_r <= in_tdata[95:64];
    end

    // output register load
    if (out_load) begin
      out_data_r <= cmd_word;
      out_flag_r <= cmd_flag;
    end

    // multiplier and divider sub-steps
    if (state_r == ST_RUN && (cw.op == OP_MUL || cw.op == OP_SAT)) begin
      if (ph_r == 5'd0) begin
        neg_r  <= opa[VW-1];
        mag_r  <= ML_W'(abs_a[MAG_W-1:0]);
        coef_r <= coef_sel;
        rem_r  <= {1'b0, abs_a[31:0]};
        q_r    <= '0;
      end else if (cw.op == OP_MUL) begin
        case (ph_r)
          5'd1: p_r <= prod;
          5'd2: begin
            lo_r <= p_r;
            p_r  <= prod;
          end
          5'd3: full_r <= PW'(lo_r) + (PW'(p_r) << 32);
          default: ;
        endcase
      end else if (ph_r != SAT_LAST) begin
        rem_r <= div_ge ? (rem_sh - {1'b0, boundary_r}) : rem_sh;
        q_r   <= {q_r[15:0], div_ge};
      end
    end

    // result write-back
    if (state_r == ST_RUN && wr_en) begin
      case (cw.dst)
        R_A:    a_r    <= res_val;
        R_X:    x_r    <= res_val;
        R_DT:   dt_r   <= res_val;
        R_DDT:  ddt_r  <= res_val;
        R_ERR:  err_r  <= res_val;
        R_DERR: derr_r <= res_val;
        R_S:    s_r    <= res_val;
        R_SUM:  sum_r  <= res_val;
        R_CMD:  cmd_r  <= res_val;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
